### src/ida_pkg.sv
`timescale 1ns / 1ps
// package for the indexed insert/delete list: field widths, op and status codes,
// word types and sequencer states; no dependencies
package ida_pkg;

   localparam int OP_W     = 2;
   localparam int POS_W    = 7;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   localparam int DEFAULT_DEPTH = 64;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] new_value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic signed [DATA_W-1:0] read_value;
      logic [COUNT_W-1:0]       entry_count;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_UP_READ,
      S_UP_WRITE,
      S_DN_READ,
      S_DN_WRITE,
      S_RD_ADDR,
      S_RD_CAP,
      S_RESP
   } state_type;

endpackage

### src/ida_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for request and response words
// depends on ida_pkg
interface ida_req_if;
   logic             valid;
   logic             ready;
   ida_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ida_rsp_if;
   logic             valid;
   logic             ready;
   ida_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### src/indexed_insert_delete_array_top.sv
`timescale 1ns / 1ps
// packed list of signed words with insert, delete and read at an index
// depends on ida_pkg and ida_if
//
// channel   dir  word                                     handshake
// req_ch    in   op, position, new_value                  valid/ready
// rsp_ch    out  status, read_value, entry_count          valid/ready
//
// one word at a time; the list lives in a one-read one-write memory, so each
// moved entry passes through a read state and a write state
// insert walks down from the top to the slot, delete walks up from the slot, read
// passes address and capture states, a rejected or unused op goes straight to rsp
// synchronous reset clears the fill count and the sequencer; the memory is not cleared
// req_ch.ready is high only between words; a response holds until rsp_ch.ready
module indexed_insert_delete_array_top #(
   parameter int DEPTH = ida_pkg::DEFAULT_DEPTH
) (
   input logic      clock,
   input logic      reset,
   ida_req_if.sink  req_ch,
   ida_rsp_if.source rsp_ch
);
   import ida_pkg::*;

   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic signed [DATA_W-1:0] mem [DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;
   logic [AW-1:0]            rd_addr;
   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic signed [DATA_W-1:0] wr_data;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [AW-1:0]            idx_ff, idx_in;
   logic [AW-1:0]            pos_ff, pos_in;
   logic signed [DATA_W-1:0] val_ff, val_in;
   logic [STATUS_W-1:0]      status_ff, status_in;
   logic signed [DATA_W-1:0] read_ff, read_in;

   logic [CMP_W-1:0]         pos_ext;
   logic [CMP_W-1:0]         cnt_ext;
   logic [CNT_W-1:0]         idx_next;

   // list storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      status_ff <= status_in;
      read_ff   <= read_in;
   end

   assign pos_ext  = CMP_W'(req_ch.data.position);
   assign cnt_ext  = CMP_W'(cnt_ff);
   assign idx_next = CNT_W'(idx_ff) + CNT_W'(1);

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      val_in    = val_ff;
      status_in = status_ff;
      read_in   = read_ff;
      rd_addr   = idx_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff;
      wr_data   = rd_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               pos_in    = AW'(req_ch.data.position);
               idx_in    = AW'(req_ch.data.position);
               val_in    = req_ch.data.new_value;
               status_in = ST_DONE;
               read_in   = '0;
               state_in  = S_RESP;
               unique case (req_ch.data.op)
                  OP_INSERT: begin
                     if (pos_ext > cnt_ext) begin
                        status_in = ST_BAD_POS;
                     end else if (cnt_ff >= FULL_CNT) begin
                        status_in = ST_FULL;
                     end else begin
                        // start at the top and walk down to the insert slot
                        idx_in   = AW'(cnt_ff);
                        state_in = S_UP_READ;
                     end
                  end
                  OP_DELETE: begin
                     if (pos_ext >= cnt_ext) begin
                        status_in = ST_BAD_POS;
                     end else begin
                        state_in = S_DN_READ;
                     end
                  end
                  OP_READ: begin
                     if (pos_ext >= cnt_ext) begin
                        status_in = ST_BAD_POS;
                     end else begin
                        state_in = S_RD_ADDR;
                     end
                  end
                  default: begin
                     status_in = ST_DONE;
                  end
               endcase
            end
         end
         S_UP_READ: begin
            rd_addr = idx_ff - AW'(1);
            if (idx_ff == pos_ff) begin
               wr_en    = 1'b1;
               wr_addr  = pos_ff;
               wr_data  = val_ff;
               cnt_in   = cnt_ff + CNT_W'(1);
               state_in = S_RESP;
            end else begin
               state_in = S_UP_WRITE;
            end
         end
         S_UP_WRITE: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff;
            wr_data  = rd_data_ff;
            idx_in   = idx_ff - AW'(1);
            state_in = S_UP_READ;
         end
         S_DN_READ: begin
            rd_addr = AW'(idx_next);
            if (idx_next >= cnt_ff) begin
               cnt_in   = cnt_ff - CNT_W'(1);
               state_in = S_RESP;
            end else begin
               state_in = S_DN_WRITE;
            end
         end
         S_DN_WRITE: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff;
            wr_data  = rd_data_ff;
            idx_in   = AW'(idx_next);
            state_in = S_DN_READ;
         end
         S_RD_ADDR: begin
            rd_addr  = idx_ff;
            state_in = S_RD_CAP;
         end
         S_RD_CAP: begin
            read_in  = rd_data_ff;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ch.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_ch.ready            = (state_ff == S_IDLE);
   assign rsp_ch.valid            = (state_ff == S_RESP);
   assign rsp_ch.data.status      = status_ff;
   assign rsp_ch.data.read_value  = read_ff;
   assign rsp_ch.data.entry_count = COUNT_W'(cnt_ff);

endmodule

### tb/indexed_insert_delete_array_top_test.sv
`timescale 1ns / 1ps
// self-checking testbench for indexed_insert_delete_array_top: a scoreboard class
// predicts every response word; depends on ida_pkg, ida_if and the top level
module indexed_insert_delete_array_top_test;
   import ida_pkg::*;

   localparam int LIST_DEPTH = DEFAULT_DEPTH;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_SEGMENTS = 6;
   localparam int SEGMENT_WORDS = 75;
   localparam int MAX_GAP = 18;
   localparam int CYCLE_LIMIT = 600000;

   class list_scoreboard;
      logic signed [DATA_W-1:0] entries[LIST_DEPTH];
      int fill_count;
      rsp_type expected_responses[$];
      int mismatches;

      function new();
         fill_count = 0;
         mismatches = 0;
      endfunction

      task report_mismatch(string what, longint exp_val, longint got_val);
         $display("[%0t] %s: expected %0d, got %0d", $time, what, exp_val, got_val);
         mismatches++;
      endtask

      function int pending();
         return expected_responses.size();
      endfunction

      // apply one accepted request word to the shadow list
      function void note_request(req_type w);
         rsp_type e;
         int pos;
         pos = int'(w.position);
         e.status = ST_DONE;
         e.read_value = '0;
         case (w.op)
            OP_INSERT: begin
               if (pos > fill_count) begin
                  e.status = ST_BAD_POS;
               end else if (fill_count >= LIST_DEPTH) begin
                  e.status = ST_FULL;
               end else begin
                  for (int i = fill_count; i > pos; i--) entries[i] = entries[i-1];
                  entries[pos] = w.new_value;
                  fill_count++;
               end
            end
            OP_DELETE: begin
               if (pos >= fill_count) begin
                  e.status = ST_BAD_POS;
               end else begin
                  for (int i = pos; i + 1 < fill_count; i++) entries[i] = entries[i+1];
                  fill_count--;
               end
            end
            OP_READ: begin
               if (pos >= fill_count) begin
                  e.status = ST_BAD_POS;
               end else begin
                  e.read_value = entries[pos];
               end
            end
            default: begin
            end
         endcase
         e.entry_count = COUNT_W'(fill_count);
         expected_responses.push_back(e);
      endfunction

      task check_response(rsp_type got);
         rsp_type e;
         if (expected_responses.size() == 0) begin
            report_mismatch("response word with nothing expected", 0, 1);
         end else begin
            e = expected_responses.pop_front();
            if (got.status !== e.status)
               report_mismatch("status", e.status, got.status);
            if (got.read_value !== e.read_value)
               report_mismatch("read_value", e.read_value, got.read_value);
            if (got.entry_count !== e.entry_count)
               report_mismatch("entry_count", e.entry_count, got.entry_count);
         end
      endtask
   endclass

   logic clock;
   logic reset;
   int cycles;
   int req_quiet;
   int rsp_quiet;
   list_scoreboard sb;

   ida_req_if req_ch ();
   ida_rsp_if rsp_ch ();

   indexed_insert_delete_array_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("indexed_insert_delete_array_top: mismatch");
         $finish;
      end
   end

   // random gap per word, with occasional stretches of back-to-back words
   function automatic int draw_gap(inout int quiet_left);
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      if ($urandom_range(0, 29) == 0) quiet_left = $urandom_range(10, 40);
      return $urandom_range(0, MAX_GAP);
   endfunction

   function automatic req_type make_word(logic [OP_W-1:0] op, int pos,
                                         logic signed [DATA_W-1:0] val);
      req_type w;
      w.op = op;
      w.position = POS_W'(pos);
      w.new_value = val;
      return w;
   endfunction

   task automatic send_request(req_type w);
      int gap;
      gap = draw_gap(req_quiet);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= w;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(w);
   endtask

   task automatic run_directed();
      send_request(make_word(OP_READ, 0, 32'sd5));
      send_request(make_word(OP_DELETE, 0, 32'sd0));
      send_request(make_word(OP_INSERT, 1, 32'sd7));
      send_request(make_word(OP_INSERT, 127, -32'sd1));
      send_request(make_word(OP_UNUSED, 0, 32'sd9));
      send_request(make_word(OP_INSERT, 0, 32'sh7fffffff));
      send_request(make_word(OP_INSERT, 0, 32'sh80000000));
      send_request(make_word(OP_INSERT, 2, -32'sd1));
      send_request(make_word(OP_INSERT, 1, 32'sd0));
      send_request(make_word(OP_INSERT, 6, 32'sd3));
      for (int i = 0; i < 4; i++) send_request(make_word(OP_READ, i, 32'sd0));
      send_request(make_word(OP_READ, 4, 32'sd0));
      send_request(make_word(OP_READ, 127, 32'sd0));
      send_request(make_word(OP_DELETE, 3, 32'sd0));
      send_request(make_word(OP_DELETE, 0, 32'sd0));
      send_request(make_word(OP_DELETE, 4, 32'sd0));
      send_request(make_word(OP_DELETE, 127, 32'sd0));
      send_request(make_word(OP_READ, 0, 32'sd0));
      send_request(make_word(OP_READ, 1, 32'sd0));
      send_request(make_word(OP_UNUSED, 127, -32'sd1));
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 15))
         0: return 32'sh80000000;
         1: return 32'sh7fffffff;
         2: return 32'sd0;
         3: return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   // mostly legal positions against the current count, some edges and noise
   function automatic int pick_position(logic [OP_W-1:0] op, int count);
      int r;
      r = $urandom_range(0, 9);
      if (r <= 5) begin
         if (op == OP_INSERT) return $urandom_range(0, count);
         if (count > 0) return $urandom_range(0, count - 1);
         return 0;
      end
      if (r == 6) return count;
      if (r == 7) return (count + 1 > 127) ? 127 : count + 1;
      return $urandom_range(0, 127);
   endfunction

   task automatic run_random();
      int insert_weight[RANDOM_SEGMENTS] = '{70, 95, 20, 50, 95, 10};
      int r;
      logic [OP_W-1:0] op;
      for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
         for (int n = 0; n < SEGMENT_WORDS; n++) begin
            r = $urandom_range(0, 99);
            if (r < insert_weight[seg]) begin
               op = OP_INSERT;
            end else begin
               r = $urandom_range(0, 99);
               op = (r < 45) ? OP_DELETE : (r < 95) ? OP_READ : OP_UNUSED;
            end
            send_request(make_word(op, pick_position(op, sb.fill_count), pick_value()));
         end
      end
   endtask

   // response side: random stall before each word
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = draw_gap(rsp_quiet);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         sb.check_response(rsp_ch.data);
      end
   end

   initial begin
      sb = new();
      req_quiet = 0;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_random();
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.pending() != 0)
         sb.report_mismatch("response words left over", 0, sb.pending());
      if (sb.mismatches == 0) begin
         $display("indexed_insert_delete_array_top: match");
      end else begin
         $display("indexed_insert_delete_array_top: mismatch");
      end
      $finish;
   end

endmodule
